[design/tls_pkg.sv]
// Shared types, widths and constants of the tetrahedron stiffness unit.
`default_nettype none
package tls_pkg;
   localparam int IN_WIDTH  = 32;
   localparam int TAG_W     = 24;
   localparam int VOL_W     = 32;
   localparam int COND_W    = 32;
   localparam int COEF_W    = COND_W + VOL_W;
   localparam int NUM_JAC   = 9;
   localparam int NUM_GRAD  = 12;
   localparam int NUM_OUT   = 10;
   localparam int OUT_W     = 48;
   localparam logic [COND_W-1:0] COND_RESET = COND_W'(65536);

   localparam int GRAD_W    = IN_WIDTH + 2;
   localparam int PROD_W    = 2 * GRAD_W;
   localparam int DOT_W     = PROD_W + 2;
   localparam int MAG_W     = DOT_W - 1;
   localparam int MAG_LO_W  = MAG_W / 2;
   localparam int MAG_HI_W  = MAG_W - MAG_LO_W;
   localparam int COEF_LO_W = COEF_W / 2;
   localparam int COEF_HI_W = COEF_W - COEF_LO_W;
   localparam int PP_W      = MAG_HI_W + COEF_HI_W;
   localparam int M_W       = MAG_W + COEF_W;

   // product has 64 fraction bits, result 24: drop 40, then divide by 6
   localparam int RND_SHIFT = 40;
   localparam int T_W       = OUT_W + 3;
   localparam int U_W       = T_W - 1;
   localparam int U_LO_W    = U_W / 2;
   localparam int U_HI_W    = U_W - U_LO_W;
   localparam int UP_W      = 2 * U_HI_W;
   localparam int DIV_K     = U_W + 1;
   localparam int QS_W      = 2 * U_W;
   localparam int Q_W       = U_W - 1;
   localparam logic [63:0] DIV3_FULL = ((64'd1 << DIV_K) + 64'd1) / 64'd3;
   localparam logic [U_W-1:0] DIV3_M = DIV3_FULL[U_W-1:0];
   localparam logic [Q_W-1:0] LIM_POS = (Q_W'(1) << (OUT_W - 1)) - Q_W'(1);

   localparam int BACK_STAGES = 10;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int PAIR_ROW [0:NUM_OUT-1] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
   localparam int PAIR_COL [0:NUM_OUT-1] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};

   typedef logic [NUM_JAC-1:0][IN_WIDTH-1:0] jac_type;

   typedef struct packed {
      logic [TAG_W-1:0]                   tag;
      logic [COEF_W-1:0]                  coef;
      logic [NUM_GRAD-1:0][GRAD_W-1:0]    grad;
   } entry_type;
endpackage
`default_nettype wire

[design/tet_local_stiffness_unit.sv]
// Top level of the linear tetrahedron local stiffness unit.
// Path from request acceptance to rsp_valid: front register,
// four-deep queue, ten-stage arithmetic pipeline with output register.
// Throughput: one request per cycle while rsp_stall stays low.
// Reset: synchronous, clears all valid state; conductivity returns to 1.0.
`default_nettype none
module tet_local_stiffness_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [23:0] req_element_index,
   input  wire logic [31:0] req_volume,
   input  wire logic [tls_pkg::IN_WIDTH-1:0] req_inv_jac_00,
   input  wire logic [tls_pkg::IN_WIDTH-1:0] req_inv_jac_01,
   input  wire logic [tls_pkg::IN_WIDTH-1:0] req_inv_jac_02,
   input  wire logic [tls_pkg::IN_WIDTH-1:0] req_inv_jac_10,
   input  wire logic [tls_pkg::IN_WIDTH-1:0] req_inv_jac_11,
   input  wire logic [tls_pkg::IN_WIDTH-1:0] req_inv_jac_12,
   input  wire logic [tls_pkg::IN_WIDTH-1:0] req_inv_jac_20,
   input  wire logic [tls_pkg::IN_WIDTH-1:0] req_inv_jac_21,
   input  wire logic [tls_pkg::IN_WIDTH-1:0] req_inv_jac_22,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [23:0]      rsp_tag_out,
   output logic [47:0]      rsp_stiff_0_0,
   output logic [47:0]      rsp_stiff_0_1,
   output logic [47:0]      rsp_stiff_0_2,
   output logic [47:0]      rsp_stiff_0_3,
   output logic [47:0]      rsp_stiff_1_1,
   output logic [47:0]      rsp_stiff_1_2,
   output logic [47:0]      rsp_stiff_1_3,
   output logic [47:0]      rsp_stiff_2_2,
   output logic [47:0]      rsp_stiff_2_3,
   output logic [47:0]      rsp_stiff_3_3,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);
   logic [tls_pkg::COND_W-1:0] conductivity_ff, conductivity_in;
   tls_pkg::jac_type           jac;
   logic                       push_valid, push_ready, pop_valid, pop;
   tls_pkg::entry_type         push_entry, pop_entry;
   logic [tls_pkg::NUM_OUT-1:0][tls_pkg::OUT_W-1:0] stiff;

   assign conductivity_in = csr_wr_en ? csr_wr_data : conductivity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         conductivity_ff <= tls_pkg::COND_RESET;
      end else begin
         conductivity_ff <= conductivity_in;
      end
   end

   assign jac = {req_inv_jac_22, req_inv_jac_21, req_inv_jac_20,
                 req_inv_jac_12, req_inv_jac_11, req_inv_jac_10,
                 req_inv_jac_02, req_inv_jac_01, req_inv_jac_00};

   tls_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_tag      (req_element_index),
      .req_volume   (req_volume),
      .req_jac      (jac),
      .conductivity (conductivity_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_entry   (push_entry)
   );

   tls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   tls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_entry  (pop_entry),
      .in_pop    (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_tag   (rsp_tag_out),
      .rsp_stiff (stiff)
   );

   assign rsp_stiff_0_0 = stiff[0];
   assign rsp_stiff_0_1 = stiff[1];
   assign rsp_stiff_0_2 = stiff[2];
   assign rsp_stiff_0_3 = stiff[3];
   assign rsp_stiff_1_1 = stiff[4];
   assign rsp_stiff_1_2 = stiff[5];
   assign rsp_stiff_1_3 = stiff[6];
   assign rsp_stiff_2_2 = stiff[7];
   assign rsp_stiff_2_3 = stiff[8];
   assign rsp_stiff_3_3 = stiff[9];
endmodule
`default_nettype wire

[design/tls_front.sv]
// Front end: takes requests, forms gradients and the k*volume coefficient.
`default_nettype none
module tls_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [tls_pkg::TAG_W-1:0] req_tag,
   input  wire logic [tls_pkg::VOL_W-1:0] req_volume,
   input  wire tls_pkg::jac_type          req_jac,
   input  wire logic [tls_pkg::COND_W-1:0] conductivity,
   output logic                           push_valid,
   input  wire logic                      push_ready,
   output tls_pkg::entry_type             push_entry
);
   logic               valid_ff, valid_in;
   tls_pkg::entry_type entry_ff, entry_in;
   logic               accept, push;
   logic signed [tls_pkg::GRAD_W-1:0] row_sum;

   assign push      = valid_ff && push_ready;
   assign req_stall = valid_ff && !push_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      entry_in.tag  = req_tag;
      entry_in.coef = tls_pkg::COEF_W'(conductivity) * tls_pkg::COEF_W'(req_volume);
      entry_in.grad = '0;
      for (int k = 0; k < 3; k++) begin
         row_sum = tls_pkg::GRAD_W'($signed(req_jac[k*3]))
                 + tls_pkg::GRAD_W'($signed(req_jac[k*3+1]))
                 + tls_pkg::GRAD_W'($signed(req_jac[k*3+2]));
         entry_in.grad[k] = -row_sum;
         for (int c = 0; c < 3; c++) begin
            entry_in.grad[(c+1)*3+k] = tls_pkg::GRAD_W'($signed(req_jac[k*3+c]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_entry = entry_ff;
endmodule
`default_nettype wire

[design/tls_queue.sv]
// Short request queue between the front end and the arithmetic pipeline.
`default_nettype none
module tls_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire tls_pkg::entry_type push_entry,
   output logic                    pop_valid,
   input  wire logic               pop,
   output tls_pkg::entry_type      pop_entry
);
   tls_pkg::entry_type mem_ff [tls_pkg::QUEUE_DEPTH];
   logic [tls_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [tls_pkg::QPTR_W:0]   count_ff, count_in;
   logic                       do_push, do_pop;

   assign push_ready = count_ff != (tls_pkg::QPTR_W+1)'(tls_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end
endmodule
`default_nettype wire

[design/tls_back.sv]
// Arithmetic pipeline: dot products, scaling, divide by six, rounding, saturation.
`default_nettype none
module tls_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire tls_pkg::entry_type in_entry,
   output logic                    in_pop,
   input  wire logic               rsp_stall,
   output logic                    rsp_valid,
   output logic [tls_pkg::TAG_W-1:0] rsp_tag,
   output logic [tls_pkg::NUM_OUT-1:0][tls_pkg::OUT_W-1:0] rsp_stiff
);
   localparam int NS = tls_pkg::BACK_STAGES;
   localparam int NO = tls_pkg::NUM_OUT;

   logic [NS-1:0] vld_ff, vld_in;
   logic [NS-1:0][tls_pkg::TAG_W-1:0] tag_ff, tag_in;
   logic advance;

   tls_pkg::entry_type s0_ff;
   logic [tls_pkg::COEF_W-1:0] coef1_ff, coef2_ff, coef3_ff;
   logic signed [tls_pkg::PROD_W-1:0] prod_ff [NO][3], prod_in [NO][3];
   logic signed [tls_pkg::DOT_W-1:0]  dot_ff [NO], dot_in [NO];
   logic [tls_pkg::MAG_W-1:0] mag_ff [NO], mag_in [NO];
   logic [tls_pkg::PP_W-1:0]  pp_ff [NO][4], pp_in [NO][4];
   logic [tls_pkg::M_W-1:0]   m_ff [NO], m_in [NO];
   logic [tls_pkg::U_W-1:0]   u_ff [NO], u_in [NO];
   logic [tls_pkg::UP_W-1:0]  up_ff [NO][4], up_in [NO][4];
   logic [tls_pkg::Q_W-1:0]   q_ff [NO], q_in [NO];
   logic [NO-1:0][tls_pkg::OUT_W-1:0] out_ff, out_in;
   logic [NO-1:0] neg3_ff, neg3_in, neg4_ff, neg5_ff, neg6_ff, neg7_ff, neg8_ff;
   logic [NO-1:0] big6_ff, big6_in, big7_ff, big8_ff;

   logic [tls_pkg::DOT_W-1:0]     absv;
   logic [tls_pkg::T_W+1:0]       t;
   logic [tls_pkg::QS_W-1:0]      qs;
   logic [tls_pkg::Q_W-1:0]       limit, mag_q;

   assign advance = !(vld_ff[NS-1] && rsp_stall);
   assign in_pop  = advance && in_valid;

   always_comb begin
      vld_in = {vld_ff[NS-2:0], in_valid};
      tag_in = {tag_ff[NS-2:0], in_entry.tag};
   end

   always_comb begin
      for (int p = 0; p < NO; p++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[p][k] = $signed(s0_ff.grad[tls_pkg::PAIR_ROW[p]*3+k])
                          * $signed(s0_ff.grad[tls_pkg::PAIR_COL[p]*3+k]);
         end
         dot_in[p] = tls_pkg::DOT_W'(prod_ff[p][0]) + tls_pkg::DOT_W'(prod_ff[p][1])
                   + tls_pkg::DOT_W'(prod_ff[p][2]);
         neg3_in[p] = dot_ff[p][tls_pkg::DOT_W-1];
         absv       = neg3_in[p] ? -dot_ff[p] : dot_ff[p];
         mag_in[p]  = absv[tls_pkg::MAG_W-1:0];
         pp_in[p][0] = tls_pkg::PP_W'(mag_ff[p][tls_pkg::MAG_LO_W-1:0])
                     * tls_pkg::PP_W'(coef3_ff[tls_pkg::COEF_LO_W-1:0]);
         pp_in[p][1] = tls_pkg::PP_W'(mag_ff[p][tls_pkg::MAG_LO_W-1:0])
                     * tls_pkg::PP_W'(coef3_ff[tls_pkg::COEF_W-1:tls_pkg::COEF_LO_W]);
         pp_in[p][2] = tls_pkg::PP_W'(mag_ff[p][tls_pkg::MAG_W-1:tls_pkg::MAG_LO_W])
                     * tls_pkg::PP_W'(coef3_ff[tls_pkg::COEF_LO_W-1:0]);
         pp_in[p][3] = tls_pkg::PP_W'(mag_ff[p][tls_pkg::MAG_W-1:tls_pkg::MAG_LO_W])
                     * tls_pkg::PP_W'(coef3_ff[tls_pkg::COEF_W-1:tls_pkg::COEF_LO_W]);
         m_in[p] = tls_pkg::M_W'(pp_ff[p][0])
                 + (tls_pkg::M_W'(pp_ff[p][1]) << tls_pkg::COEF_LO_W)
                 + (tls_pkg::M_W'(pp_ff[p][2]) << tls_pkg::MAG_LO_W)
                 + (tls_pkg::M_W'(pp_ff[p][3]) << (tls_pkg::MAG_LO_W + tls_pkg::COEF_LO_W));
         // round half away: add 3 in units of 2^40 before dividing by six
         t = {1'b0, m_ff[p][tls_pkg::RND_SHIFT+tls_pkg::T_W:tls_pkg::RND_SHIFT]}
           + (tls_pkg::T_W+2)'(3);
         big6_in[p] = (|m_ff[p][tls_pkg::M_W-1:tls_pkg::RND_SHIFT+tls_pkg::T_W+1])
                    || (|t[tls_pkg::T_W+1:tls_pkg::T_W]);
         u_in[p] = t[tls_pkg::T_W-1:1];
         // divide by three through the reciprocal, split in four products
         up_in[p][0] = tls_pkg::UP_W'(u_ff[p][tls_pkg::U_LO_W-1:0])
                     * tls_pkg::UP_W'(tls_pkg::DIV3_M[tls_pkg::U_LO_W-1:0]);
         up_in[p][1] = tls_pkg::UP_W'(u_ff[p][tls_pkg::U_LO_W-1:0])
                     * tls_pkg::UP_W'(tls_pkg::DIV3_M[tls_pkg::U_W-1:tls_pkg::U_LO_W]);
         up_in[p][2] = tls_pkg::UP_W'(u_ff[p][tls_pkg::U_W-1:tls_pkg::U_LO_W])
                     * tls_pkg::UP_W'(tls_pkg::DIV3_M[tls_pkg::U_LO_W-1:0]);
         up_in[p][3] = tls_pkg::UP_W'(u_ff[p][tls_pkg::U_W-1:tls_pkg::U_LO_W])
                     * tls_pkg::UP_W'(tls_pkg::DIV3_M[tls_pkg::U_W-1:tls_pkg::U_LO_W]);
         qs = tls_pkg::QS_W'(up_ff[p][0])
            + ((tls_pkg::QS_W'(up_ff[p][1]) + tls_pkg::QS_W'(up_ff[p][2])) << tls_pkg::U_LO_W)
            + (tls_pkg::QS_W'(up_ff[p][3]) << (2 * tls_pkg::U_LO_W));
         q_in[p] = qs[tls_pkg::QS_W-1:tls_pkg::DIV_K];
         limit = neg8_ff[p] ? tls_pkg::LIM_POS + 1'b1 : tls_pkg::LIM_POS;
         mag_q = (big8_ff[p] || q_ff[p] > limit) ? limit : q_ff[p];
         out_in[p] = neg8_ff[p] ? tls_pkg::OUT_W'(0) - mag_q[tls_pkg::OUT_W-1:0]
                                : mag_q[tls_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff   <= tag_in;
         s0_ff    <= in_entry;
         coef1_ff <= s0_ff.coef;
         coef2_ff <= coef1_ff;
         coef3_ff <= coef2_ff;
         prod_ff  <= prod_in;
         dot_ff   <= dot_in;
         neg3_ff  <= neg3_in;
         mag_ff   <= mag_in;
         neg4_ff  <= neg3_ff;
         pp_ff    <= pp_in;
         neg5_ff  <= neg4_ff;
         m_ff     <= m_in;
         neg6_ff  <= neg5_ff;
         big6_ff  <= big6_in;
         u_ff     <= u_in;
         neg7_ff  <= neg6_ff;
         big7_ff  <= big6_ff;
         up_ff    <= up_in;
         neg8_ff  <= neg7_ff;
         big8_ff  <= big7_ff;
         q_ff     <= q_in;
         out_ff   <= out_in;
      end
   end

   assign rsp_valid = vld_ff[NS-1];
   assign rsp_tag   = tag_ff[NS-1];
   assign rsp_stiff = out_ff;
endmodule
`default_nettype wire

[tb/sv/tet_local_stiffness_unit_tb.sv]
// Testbench for the tetrahedron local stiffness unit: random and corner elements.
`timescale 1ns / 100ps
`default_nettype none
module tet_local_stiffness_unit_tb;
   typedef logic signed [tls_pkg::IN_WIDTH-1:0] jac_word_type;

   typedef struct {
      logic                       is_cfg;
      logic [tls_pkg::COND_W-1:0] cfg_val;
      logic [tls_pkg::TAG_W-1:0]  tag;
      logic [tls_pkg::VOL_W-1:0]  vol;
      jac_word_type               jac [tls_pkg::NUM_JAC];
   } elem_req_type;

   typedef struct {
      logic [tls_pkg::TAG_W-1:0] tag;
      logic [tls_pkg::OUT_W-1:0] stiff [tls_pkg::NUM_OUT];
   } stiff_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [23:0] req_element_index = '0;
   logic [31:0] req_volume = '0;
   jac_word_type req_jac [tls_pkg::NUM_JAC] = '{default: '0};
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [23:0] rsp_tag_out;
   logic [47:0] rsp_stiff [tls_pkg::NUM_OUT];
   logic csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   elem_req_type  pending_q [$];
   stiff_rsp_type matrix_q [$];
   logic [tls_pkg::COND_W-1:0] model_cond;
   int  fail_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  req_taken = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tet_local_stiffness_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_element_index(req_element_index), .req_volume(req_volume),
      .req_inv_jac_00(req_jac[0]), .req_inv_jac_01(req_jac[1]), .req_inv_jac_02(req_jac[2]),
      .req_inv_jac_10(req_jac[3]), .req_inv_jac_11(req_jac[4]), .req_inv_jac_12(req_jac[5]),
      .req_inv_jac_20(req_jac[6]), .req_inv_jac_21(req_jac[7]), .req_inv_jac_22(req_jac[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_tag_out(rsp_tag_out),
      .rsp_stiff_0_0(rsp_stiff[0]), .rsp_stiff_0_1(rsp_stiff[1]),
      .rsp_stiff_0_2(rsp_stiff[2]), .rsp_stiff_0_3(rsp_stiff[3]),
      .rsp_stiff_1_1(rsp_stiff[4]), .rsp_stiff_1_2(rsp_stiff[5]),
      .rsp_stiff_1_3(rsp_stiff[6]), .rsp_stiff_2_2(rsp_stiff[7]),
      .rsp_stiff_2_3(rsp_stiff[8]), .rsp_stiff_3_3(rsp_stiff[9]),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   function automatic stiff_rsp_type element_stiffness(elem_req_type e,
                                                       logic [tls_pkg::COND_W-1:0] k);
      stiff_rsp_type res;
      logic signed [tls_pkg::IN_WIDTH+1:0] grad [4][3];
      logic signed [2*tls_pkg::IN_WIDTH+5:0] dot;
      logic signed [191:0] prod;
      logic [191:0] mag;
      logic [191:0] lim;
      logic neg;
      res.tag = e.tag;
      for (int r = 0; r < 3; r++) begin
         grad[0][r] = -($signed(e.jac[3*r]) + $signed(e.jac[3*r+1]) + $signed(e.jac[3*r+2]));
         for (int c = 0; c < 3; c++)
            grad[c+1][r] = $signed(e.jac[3*r+c]);
      end
      for (int p = 0; p < tls_pkg::NUM_OUT; p++) begin
         dot = '0;
         for (int i = 0; i < 3; i++)
            dot += grad[tls_pkg::PAIR_ROW[p]][i] * grad[tls_pkg::PAIR_COL[p]][i];
         prod = dot * $signed({1'b0, 64'(k) * 64'(e.vol)});
         neg = prod < 0;
         mag = neg ? -prod : prod;
         mag = ((mag + (192'd3 << 40)) >> 40) / 192'd6;
         lim = neg ? (192'd1 << 47) : ((192'd1 << 47) - 1);
         if (mag > lim) mag = lim;
         res.stiff[p] = neg ? -mag[47:0] : mag[47:0];
      end
      return res;
   endfunction

   function automatic jac_word_type rand_jac_word();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(tls_pkg::IN_WIDTH-1){1'b0}}};
         1: return {1'b0, {(tls_pkg::IN_WIDTH-1){1'b1}}};
         2, 3, 4: return jac_word_type'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
         5: return '0;
         default: return jac_word_type'($urandom);
      endcase
   endfunction

   task automatic add_element(logic [tls_pkg::TAG_W-1:0] tag, logic [tls_pkg::VOL_W-1:0] vol,
                              jac_word_type fill, bit randomize_jac);
      elem_req_type e;
      e.is_cfg = 1'b0;
      e.cfg_val = '0;
      e.tag = tag;
      e.vol = vol;
      foreach (e.jac[i]) e.jac[i] = randomize_jac ? rand_jac_word() : fill;
      pending_q.push_back(e);
   endtask

   task automatic add_cfg(logic [tls_pkg::COND_W-1:0] v);
      elem_req_type e;
      e.is_cfg = 1'b1;
      e.cfg_val = v;
      e.tag = '0;
      e.vol = '0;
      foreach (e.jac[i]) e.jac[i] = '0;
      pending_q.push_back(e);
   endtask

   // driver: config entries wait for an idle block before writing
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // request still waiting, hold it
         end else if (pending_q.size() == 0) begin
            req_valid <= 1'b0;
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_q[0].is_cfg) begin
            req_valid <= 1'b0;
            if (matrix_q.size() == 0 && !csr_wr_en) begin
               csr_wr_en <= 1'b1;
               csr_wr_data <= pending_q[0].cfg_val;
            end else if (csr_wr_en) begin
               csr_wr_en <= 1'b0;
               void'(pending_q.pop_front());
            end
         end else begin
            req_valid <= 1'b1;
            req_element_index <= pending_q[0].tag;
            req_volume <= pending_q[0].vol;
            for (int i = 0; i < tls_pkg::NUM_JAC; i++) req_jac[i] <= pending_q[0].jac[i];
            void'(pending_q.pop_front());
            send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                      : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                        : $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // predictor runs at request acceptance; conductivity tracks csr writes
   always @(posedge clock) begin
      elem_req_type e;
      stiff_rsp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (reset) begin
         model_cond <= tls_pkg::COND_RESET;
      end else begin
         if (csr_wr_en) model_cond <= csr_wr_data;
         if (req_valid && !req_stall) begin
            e.is_cfg = 1'b0;
            e.cfg_val = '0;
            e.tag = req_element_index;
            e.vol = req_volume;
            foreach (e.jac[i]) e.jac[i] = req_jac[i];
            matrix_q.push_back(element_stiffness(e, model_cond));
         end
         if (rsp_valid && !rsp_stall) begin
            if (matrix_q.size() == 0) begin
               $error("unexpected response tag %0h", rsp_tag_out);
               fail_count++;
            end else begin
               want = matrix_q.pop_front();
               if (rsp_tag_out !== want.tag) begin
                  $error("tag_out expected %0h actual %0h", want.tag, rsp_tag_out);
                  fail_count++;
               end
               for (int p = 0; p < tls_pkg::NUM_OUT; p++)
                  if (rsp_stiff[p] !== want.stiff[p]) begin
                     $error("stiff_%0d_%0d expected %0h actual %0h",
                            tls_pkg::PAIR_ROW[p], tls_pkg::PAIR_COL[p],
                            want.stiff[p], rsp_stiff[p]);
                     fail_count++;
                  end
            end
         end
      end
   end

   initial begin
      logic [tls_pkg::COND_W-1:0] conds [6];
      conds = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0003_8000, 32'h0001_0000};
      // directed: extremes of volume and Jacobian entries
      add_element(24'h0, 32'h0001_0000, 32'sh0001_0000, 0);
      add_element(24'hFFFFFF, 32'hFFFF_FFFF, {1'b1, {(tls_pkg::IN_WIDTH-1){1'b0}}}, 0);
      add_element(24'h123456, 32'hFFFF_FFFF, {1'b0, {(tls_pkg::IN_WIDTH-1){1'b1}}}, 0);
      add_element(24'h000001, 32'h0, 32'sh7FFF_FFFF, 0);
      add_element(24'h800000, 32'h0000_0001, 32'sh0000_0001, 0);
      add_element(24'h555555, 32'h0000_0006, -32'sh0000_0001, 0);
      add_element(24'hAAAAAA, 32'h0000_0003, 32'sh0000_0001, 0);
      for (int i = 0; i < 10; i++) add_element(24'($urandom), $urandom, '0, 1);
      for (int ph = 0; ph < 6; ph++) begin
         add_cfg(conds[ph] ^ ((ph == 5) ? $urandom : 32'h0));
         for (int i = 0; i < 250; i++)
            add_element(24'($urandom), ($urandom_range(0, 3) == 0) ? $urandom
                        : $urandom_range(0, 32'h000F_FFFF), '0, 1);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0 && !req_valid);
      wait (matrix_q.size() == 0);
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire
